// File: rtl/core/owbg_pkg.sv
// shared constants and types for the white balance gain core
// no dependencies
package owbg_pkg;

   localparam int unsigned RATIO_W = 10;
   localparam int unsigned CMP_W   = 16;
   localparam int unsigned GAIN_W  = 16;
   localparam int unsigned NUM1_W  = 24;
   localparam int unsigned NUM2_W  = 30;
   localparam int unsigned IDX_W   = 3;

   localparam logic [13:0] UNITY_SCALE = 14'd10000;
   localparam logic [15:0] UNITY_GAIN  = 16'h0400;
   localparam logic [29:0] SCALE_SQ    = 30'd100000000;

   localparam logic [7:0] MID_A = 8'h02;
   localparam logic [7:0] MID_B = 8'h06;
   localparam logic [7:0] MID_C = 8'h05;

   // gain = ratio * 64 / 625, via reciprocal 2^32 / 625
   localparam logic [22:0] GAIN_RECIP = 23'd6871947;
   localparam logic [9:0]  GAIN_DIV   = 10'd625;

   typedef enum logic [IDX_W-1:0] {
      REG_RG_A = 3'd0,
      REG_BG_A = 3'd1,
      REG_RG_B = 3'd2,
      REG_BG_B = 3'd3,
      REG_RG_C = 3'd4,
      REG_BG_C = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      CASE_BOTH = 2'd0,
      CASE_RED  = 2'd1,
      CASE_BLUE = 2'd2
   } case_type;

   typedef struct packed {
      logic valid;
      logic fail;
   } ctl_type;

endpackage

// File: rtl/core/owbg_div.sv
// pipelined restoring divider, one quotient bit per stage
// no dependencies; a zero divisor yields an all-ones quotient
module owbg_div #(
   parameter int unsigned NW = 24,
   parameter int unsigned DW = 10,
   parameter int unsigned SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_quot,
   output logic [SW-1:0] out_side
);

   logic [DW-1:0] rem_ff  [NW];
   logic [DW-1:0] rem_in  [NW];
   logic [NW-1:0] num_ff  [NW];
   logic [NW-1:0] num_in  [NW];
   logic [DW-1:0] den_ff  [NW];
   logic [SW-1:0] side_ff [NW];
   logic [NW-1:0] valid_ff;
   logic [NW-1:0] valid_in;

   logic [DW-1:0] pr_rem  [NW];
   logic [NW-1:0] pr_num  [NW];
   logic [DW-1:0] pr_den  [NW];
   logic [SW-1:0] pr_side [NW];
   logic [DW:0]   trial   [NW];
   logic [NW-1:0] ge;

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         if (i == 0) begin
            pr_rem[i]   = '0;
            pr_num[i]   = in_num;
            pr_den[i]   = in_den;
            pr_side[i]  = in_side;
            valid_in[i] = in_valid;
         end else begin
            pr_rem[i]   = rem_ff[i-1];
            pr_num[i]   = num_ff[i-1];
            pr_den[i]   = den_ff[i-1];
            pr_side[i]  = side_ff[i-1];
            valid_in[i] = valid_ff[i-1];
         end
         trial[i] = {pr_rem[i], pr_num[i][NW-1]};
         ge[i]    = trial[i] >= {1'b0, pr_den[i]};
         rem_in[i] = ge[i] ? DW'(trial[i] - {1'b0, pr_den[i]}) : trial[i][DW-1:0];
         num_in[i] = {pr_num[i][NW-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NW; i++) begin
         rem_ff[i]  <= rem_in[i];
         num_ff[i]  <= num_in[i];
         den_ff[i]  <= pr_den[i];
         side_ff[i] <= pr_side[i];
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_quot  = num_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

// File: rtl/core/owbg_gain.sv
// ratio to gain conversion, two register stages
// depends on owbg_pkg
module owbg_gain (
   input  logic                         clock,
   input  logic [owbg_pkg::CMP_W-1:0]   ratio,
   input  logic                         fail,
   output logic [owbg_pkg::GAIN_W-1:0]  gain,
   output logic                         apply
);
   import owbg_pkg::*;

   logic [21:0]       n_ff;
   logic [21:0]       n_in;
   logic [12:0]       q_ff;
   logic [44:0]       prod;
   logic              fail_ff;
   logic              apply1_ff;
   logic              apply1_in;
   logic [21:0]       rem;
   logic [12:0]       q_fix;
   logic [GAIN_W-1:0] gain_ff;
   logic [GAIN_W-1:0] gain_in;
   logic              apply_ff;
   logic              apply_in;

   always_comb begin
      n_in      = {ratio, 6'd0};
      prod      = 45'(n_in) * 45'(GAIN_RECIP);
      apply1_in = ratio != 16'(UNITY_SCALE);
      rem       = n_ff - 22'(q_ff * 23'(GAIN_DIV));
      q_fix     = (rem >= 22'(GAIN_DIV)) ? q_ff + 13'd1 : q_ff;
      gain_in   = fail_ff ? UNITY_GAIN : 16'(q_fix);
      apply_in  = !fail_ff && apply1_ff;
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      q_ff      <= prod[44:32];
      fail_ff   <= fail;
      apply1_ff <= apply1_in;
      gain_ff   <= gain_in;
      apply_ff  <= apply_in;
   end

   assign gain  = gain_ff;
   assign apply = apply_ff;

endmodule

// File: rtl/core/otp_white_balance_gain_core.sv
// top level of the white balance gain core: golden registers, ratio
// compare and two divider rows; depends on owbg_pkg, owbg_div, owbg_gain
//
// One calibration transaction is accepted in every cycle (busy stays low)
// and its result appears on the rsp_ ports, marked by rsp_strobe, after
// one input stage, a 24-stage divider row, one compare stage, a 30-stage
// divider row and two gain stages. The divider rows retire one quotient
// bit per stage, which sets the latency. The receiver cannot stall, so
// results must be taken on the cycle they appear.
module otp_white_balance_gain_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [7:0]                   req_module_id,
   input  logic [7:0]                   req_rg_high,
   input  logic [7:0]                   req_bg_high,
   input  logic [7:0]                   req_low_bits,
   output logic                         rsp_strobe,
   output logic                         rsp_ok,
   output logic [owbg_pkg::GAIN_W-1:0]  rsp_red_gain,
   output logic [owbg_pkg::GAIN_W-1:0]  rsp_green_gain,
   output logic [owbg_pkg::GAIN_W-1:0]  rsp_blue_gain,
   output logic                         rsp_red_apply,
   output logic                         rsp_green_apply,
   output logic                         rsp_blue_apply,
   input  logic                         csr_we,
   input  logic [owbg_pkg::IDX_W-1:0]   csr_index,
   input  logic [owbg_pkg::RATIO_W-1:0] csr_wdata
);
   import owbg_pkg::*;

   localparam int unsigned SIDE2_W = 1 + 2 + CMP_W;

   logic [RATIO_W-1:0] rg_a_ff, bg_a_ff, rg_b_ff, bg_b_ff, rg_c_ff, bg_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rg_a_ff <= 10'd244;
         bg_a_ff <= 10'd285;
         rg_b_ff <= 10'd280;
         bg_b_ff <= 10'd327;
         rg_c_ff <= 10'd248;
         bg_c_ff <= 10'd288;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_index))
            REG_RG_A: rg_a_ff <= csr_wdata;
            REG_BG_A: bg_a_ff <= csr_wdata;
            REG_RG_B: rg_b_ff <= csr_wdata;
            REG_BG_B: bg_b_ff <= csr_wdata;
            REG_RG_C: rg_c_ff <= csr_wdata;
            REG_BG_C: bg_c_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage
   logic [RATIO_W-1:0] rg, bg, grg, gbg;
   ctl_type            a_ctl_ff, a_ctl_in;
   logic [NUM1_W-1:0]  a_num_rg_ff, a_num_bg_ff;
   logic [RATIO_W-1:0] a_den_rg_ff, a_den_bg_ff;

   always_comb begin
      rg = {req_rg_high, req_low_bits[7:6]};
      bg = {req_bg_high, req_low_bits[5:4]};
      grg = '0;
      gbg = '0;
      if (req_module_id == MID_A) begin
         grg = rg_a_ff;
         gbg = bg_a_ff;
      end else if (req_module_id == MID_B) begin
         grg = rg_b_ff;
         gbg = bg_b_ff;
      end else if (req_module_id == MID_C) begin
         grg = rg_c_ff;
         gbg = bg_c_ff;
      end
      a_ctl_in.valid = start && !busy;
      a_ctl_in.fail  = (grg == '0) || (gbg == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff.valid <= 1'b0;
      end else begin
         a_ctl_ff.valid <= a_ctl_in.valid;
      end
      a_ctl_ff.fail <= a_ctl_in.fail;
      a_num_rg_ff   <= NUM1_W'(rg) * NUM1_W'(UNITY_SCALE);
      a_num_bg_ff   <= NUM1_W'(bg) * NUM1_W'(UNITY_SCALE);
      a_den_rg_ff   <= grg;
      a_den_bg_ff   <= gbg;
   end

   // first divider row
   logic              d1_valid_rg, d1_valid_bg, d1_fail_rg, d1_fail_bg;
   logic [NUM1_W-1:0] d1_q_rg, d1_q_bg;

   owbg_div #(.NW(NUM1_W), .DW(RATIO_W), .SW(1)) u_div_rg (
      .clock(clock), .reset(reset),
      .in_valid(a_ctl_ff.valid), .in_num(a_num_rg_ff), .in_den(a_den_rg_ff),
      .in_side(a_ctl_ff.fail),
      .out_valid(d1_valid_rg), .out_quot(d1_q_rg), .out_side(d1_fail_rg)
   );

   owbg_div #(.NW(NUM1_W), .DW(RATIO_W), .SW(1)) u_div_bg (
      .clock(clock), .reset(reset),
      .in_valid(a_ctl_ff.valid), .in_num(a_num_bg_ff), .in_den(a_den_bg_ff),
      .in_side(a_ctl_ff.fail),
      .out_valid(d1_valid_bg), .out_quot(d1_q_bg), .out_side(d1_fail_bg)
   );

   // compare stage
   logic [CMP_W-1:0]   cmp_rg, cmp_bg, cmp_max;
   logic [NUM2_W-1:0]  prod;
   case_type           b_case_in;
   ctl_type            b_ctl_ff;
   logic [NUM2_W-1:0]  b_num_r_ff, b_num_b_ff;
   logic [CMP_W-1:0]   b_den_r_ff, b_den_b_ff, b_ratio_g_ff;
   case_type           b_case_ff;

   always_comb begin
      cmp_rg  = d1_q_rg[CMP_W-1:0];
      cmp_bg  = d1_q_bg[CMP_W-1:0];
      cmp_max = (cmp_rg > cmp_bg) ? cmp_rg : cmp_bg;
      prod    = NUM2_W'(cmp_max) * NUM2_W'(UNITY_SCALE);
      if (cmp_rg < 16'(UNITY_SCALE) && cmp_bg < 16'(UNITY_SCALE)) begin
         b_case_in = CASE_BOTH;
      end else if (cmp_rg > cmp_bg) begin
         b_case_in = CASE_RED;
      end else begin
         b_case_in = CASE_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff.valid <= 1'b0;
      end else begin
         b_ctl_ff.valid <= d1_valid_rg && d1_valid_bg;
      end
      b_ctl_ff.fail <= d1_fail_rg || d1_fail_bg;
      b_case_ff     <= b_case_in;
      b_num_r_ff    <= (b_case_in == CASE_BLUE) ? prod : SCALE_SQ;
      b_num_b_ff    <= (b_case_in == CASE_RED) ? prod : SCALE_SQ;
      b_den_r_ff    <= cmp_rg;
      b_den_b_ff    <= cmp_bg;
      b_ratio_g_ff  <= (b_case_in == CASE_BOTH) ? 16'(UNITY_SCALE) : cmp_max;
   end

   // second divider row
   logic               d2_valid_r, d2_valid_b, d2_fail_b;
   logic [NUM2_W-1:0]  d2_q_r, d2_q_b;
   logic [SIDE2_W-1:0] d2_side_r;
   case_type           c_case;
   ctl_type            c_ctl;
   logic [CMP_W-1:0]   ratio_r, ratio_g, ratio_b;

   owbg_div #(.NW(NUM2_W), .DW(CMP_W), .SW(SIDE2_W)) u_div_r (
      .clock(clock), .reset(reset),
      .in_valid(b_ctl_ff.valid), .in_num(b_num_r_ff), .in_den(b_den_r_ff),
      .in_side({b_ctl_ff.fail, b_case_ff, b_ratio_g_ff}),
      .out_valid(d2_valid_r), .out_quot(d2_q_r), .out_side(d2_side_r)
   );

   owbg_div #(.NW(NUM2_W), .DW(CMP_W), .SW(1)) u_div_b (
      .clock(clock), .reset(reset),
      .in_valid(b_ctl_ff.valid), .in_num(b_num_b_ff), .in_den(b_den_b_ff),
      .in_side(b_ctl_ff.fail),
      .out_valid(d2_valid_b), .out_quot(d2_q_b), .out_side(d2_fail_b)
   );

   always_comb begin
      c_case      = case_type'(d2_side_r[CMP_W+1:CMP_W]);
      c_ctl.valid = d2_valid_r && d2_valid_b;
      c_ctl.fail  = d2_side_r[SIDE2_W-1] || d2_fail_b;
      ratio_g     = d2_side_r[CMP_W-1:0];
      ratio_r     = (c_case == CASE_RED) ? 16'(UNITY_SCALE) : d2_q_r[CMP_W-1:0];
      ratio_b     = (c_case == CASE_BLUE) ? 16'(UNITY_SCALE) : d2_q_b[CMP_W-1:0];
   end

   // gain stages
   ctl_type g1_ctl_ff, g2_ctl_ff;

   owbg_gain u_gain_r (
      .clock(clock), .ratio(ratio_r), .fail(c_ctl.fail),
      .gain(rsp_red_gain), .apply(rsp_red_apply)
   );

   owbg_gain u_gain_g (
      .clock(clock), .ratio(ratio_g), .fail(c_ctl.fail),
      .gain(rsp_green_gain), .apply(rsp_green_apply)
   );

   owbg_gain u_gain_b (
      .clock(clock), .ratio(ratio_b), .fail(c_ctl.fail),
      .gain(rsp_blue_gain), .apply(rsp_blue_apply)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_ctl_ff.valid <= 1'b0;
         g2_ctl_ff.valid <= 1'b0;
      end else begin
         g1_ctl_ff.valid <= c_ctl.valid;
         g2_ctl_ff.valid <= g1_ctl_ff.valid;
      end
      g1_ctl_ff.fail <= c_ctl.fail;
      g2_ctl_ff.fail <= g1_ctl_ff.fail;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = g2_ctl_ff.valid;
   assign rsp_ok     = !g2_ctl_ff.fail;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 58))
      else $error("result without a transaction 58 cycles earlier");

   a_fail_unity: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_ok |-> rsp_red_gain == UNITY_GAIN
         && rsp_green_gain == UNITY_GAIN && rsp_blue_gain == UNITY_GAIN
         && !rsp_red_apply && !rsp_green_apply && !rsp_blue_apply)
      else $error("failed transaction with non-unity result");

   a_one_unity: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_ok |-> !(rsp_red_apply && rsp_green_apply && rsp_blue_apply))
      else $error("no channel left at unity");

   a_red_unity: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_ok && !rsp_red_apply |-> rsp_red_gain == UNITY_GAIN)
      else $error("unapplied red gain is not unity");
`endif

endmodule

// File: verif/owbg_checker.sv
// checker for the white balance gain core: watches the request, result and
// csr ports, predicts each result and compares it; depends on owbg_pkg
`timescale 1ns / 1ps
module owbg_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [7:0]                   req_module_id,
   input  logic [7:0]                   req_rg_high,
   input  logic [7:0]                   req_bg_high,
   input  logic [7:0]                   req_low_bits,
   input  logic                         rsp_strobe,
   input  logic                         rsp_ok,
   input  logic [owbg_pkg::GAIN_W-1:0]  rsp_red_gain,
   input  logic [owbg_pkg::GAIN_W-1:0]  rsp_green_gain,
   input  logic [owbg_pkg::GAIN_W-1:0]  rsp_blue_gain,
   input  logic                         rsp_red_apply,
   input  logic                         rsp_green_apply,
   input  logic                         rsp_blue_apply,
   input  logic                         csr_we,
   input  logic [owbg_pkg::IDX_W-1:0]   csr_index,
   input  logic [owbg_pkg::RATIO_W-1:0] csr_wdata,
   output int                           fail_count,
   output int                           pending_count,
   output logic                         activity
);
   import owbg_pkg::*;

   localparam int unsigned SCALE   = 10000;
   localparam int unsigned UGAIN   = 1024;
   localparam int unsigned SAT_Q   = 16'hffff;

   typedef struct packed {
      logic        ok;
      logic [15:0] red_gain;
      logic [15:0] green_gain;
      logic [15:0] blue_gain;
      logic        red_apply;
      logic        green_apply;
      logic        blue_apply;
   } gains_type;

   logic [9:0] mdl_rg [0:2];
   logic [9:0] mdl_bg [0:2];
   gains_type  expected_gains [$];

   function automatic int unsigned quot16(int unsigned num, int unsigned den);
      if (den == 0) return SAT_Q;
      return (num / den) & SAT_Q;
   endfunction

   function automatic logic [15:0] ratio_to_gain(int unsigned ratio, output logic apply);
      apply = (ratio != SCALE);
      if (!apply) return 16'(UGAIN);
      return 16'(((UGAIN * ratio) / SCALE) & SAT_Q);
   endfunction

   function automatic gains_type calc_gains(logic [7:0] mid, logic [7:0] rgh,
                                            logic [7:0] bgh, logic [7:0] lo);
      gains_type   g;
      int unsigned rg, bg, grg, gbg, cmp_rg, cmp_bg, r_r, r_g, r_b;
      rg  = 32'({rgh, lo[7:6]});
      bg  = 32'({bgh, lo[5:4]});
      grg = 0;
      gbg = 0;
      if (mid == MID_A) begin
         grg = 32'(mdl_rg[0]); gbg = 32'(mdl_bg[0]);
      end else if (mid == MID_B) begin
         grg = 32'(mdl_rg[1]); gbg = 32'(mdl_bg[1]);
      end else if (mid == MID_C) begin
         grg = 32'(mdl_rg[2]); gbg = 32'(mdl_bg[2]);
      end
      if (grg == 0 || gbg == 0) begin
         g = '0;
         g.red_gain = 16'(UGAIN); g.green_gain = 16'(UGAIN); g.blue_gain = 16'(UGAIN);
         return g;
      end
      cmp_rg = quot16(SCALE * rg, grg);
      cmp_bg = quot16(SCALE * bg, gbg);
      if (cmp_rg < SCALE && cmp_bg < SCALE) begin
         r_g = SCALE;
         r_r = quot16(SCALE * SCALE, cmp_rg);
         r_b = quot16(SCALE * SCALE, cmp_bg);
      end else if (cmp_rg > cmp_bg) begin
         r_r = SCALE;
         r_g = cmp_rg;
         r_b = quot16(SCALE * cmp_rg, cmp_bg);
      end else begin
         r_b = SCALE;
         r_g = cmp_bg;
         r_r = quot16(SCALE * cmp_bg, cmp_rg);
      end
      g.ok = 1'b1;
      g.red_gain   = ratio_to_gain(r_r, g.red_apply);
      g.green_gain = ratio_to_gain(r_g, g.green_apply);
      g.blue_gain  = ratio_to_gain(r_b, g.blue_apply);
      return g;
   endfunction

   gains_type seen;
   assign seen = '{rsp_ok, rsp_red_gain, rsp_green_gain, rsp_blue_gain,
                   rsp_red_apply, rsp_green_apply, rsp_blue_apply};
   assign pending_count = expected_gains.size();
   assign activity = (start && !busy) || rsp_strobe;

   always @(posedge clock) begin
      gains_type want;
      if (reset) begin
         mdl_rg[0] <= 10'd244; mdl_bg[0] <= 10'd285;
         mdl_rg[1] <= 10'd280; mdl_bg[1] <= 10'd327;
         mdl_rg[2] <= 10'd248; mdl_bg[2] <= 10'd288;
         expected_gains.delete();
         fail_count <= 0;
      end else begin
         if (start && !busy)
            expected_gains.push_back(calc_gains(req_module_id, req_rg_high,
                                                req_bg_high, req_low_bits));
         if (rsp_strobe) begin
            if (expected_gains.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected transaction: %p", seen);
            end else begin
               want = expected_gains.pop_front();
               if (want != seen) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("gain error: expected %p got %p", want, seen);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_RG_A: mdl_rg[0] <= csr_wdata;
               REG_BG_A: mdl_bg[0] <= csr_wdata;
               REG_RG_B: mdl_rg[1] <= csr_wdata;
               REG_BG_B: mdl_bg[1] <= csr_wdata;
               REG_RG_C: mdl_rg[2] <= csr_wdata;
               REG_BG_C: mdl_bg[2] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule

// File: verif/otp_white_balance_gain_core_tb.sv
// testbench top for the white balance gain core: clock, reset, stimulus
// and verdict; depends on owbg_pkg, owbg_checker and the core
`timescale 1ns / 1ps
module otp_white_balance_gain_core_tb;
   import owbg_pkg::*;

   localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
   localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 70;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [7:0] req_module_id = '0, req_rg_high = '0, req_bg_high = '0, req_low_bits = '0;
   logic rsp_strobe, rsp_ok, rsp_red_apply, rsp_green_apply, rsp_blue_apply;
   logic [GAIN_W-1:0] rsp_red_gain, rsp_green_gain, rsp_blue_gain;
   logic csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [RATIO_W-1:0] csr_wdata = '0;
   int fail_count, pending_count, quiet_cycles, idle_pct;
   logic activity;
   logic [9:0] cur_rg [0:2];
   logic [7:0] known_ids [0:2];

   always #5 clock = ~clock;

   otp_white_balance_gain_core u_dut (.*);
   owbg_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || activity) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("otp_white_balance_gain_core: mismatch");
         $finish;
      end
   end

   task automatic send_record(logic [7:0] mid, logic [7:0] rgh, logic [7:0] bgh,
                              logic [7:0] lo);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start = 1'b1;
      req_module_id = mid; req_rg_high = rgh; req_bg_high = bgh; req_low_bits = lo;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      start = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_golden(logic [IDX_W-1:0] idx, logic [9:0] val);
      csr_we = 1'b1; csr_index = idx; csr_wdata = val;
      if (idx == REG_RG_A) cur_rg[0] = val;
      if (idx == REG_RG_B) cur_rg[1] = val;
      if (idx == REG_RG_C) cur_rg[2] = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_goldens(logic [9:0] v0, logic [9:0] v1, logic [9:0] v2,
                               logic [9:0] v3, logic [9:0] v4, logic [9:0] v5);
      wait_idle();
      write_golden(REG_RG_A, v0); write_golden(REG_BG_A, v1);
      write_golden(REG_RG_B, v2); write_golden(REG_BG_B, v3);
      write_golden(REG_RG_C, v4); write_golden(REG_BG_C, v5);
      write_golden(IDX_SPARE_LO, 10'h3ff);
      write_golden(IDX_SPARE_HI, 10'h000);
   endtask

   task automatic random_records(int count);
      int k;
      logic [7:0] mid, rgh, bgh, lo;
      logic [9:0] g;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(2);
         mid = ($urandom_range(9) < 8) ? known_ids[k] : 8'($urandom);
         rgh = 8'($urandom); bgh = 8'($urandom); lo = 8'($urandom);
         if ($urandom_range(9) == 0) begin
            // module ratio equal to the golden one
            g = cur_rg[k];
            rgh = g[9:2]; lo[7:6] = g[1:0];
         end
         if ($urandom_range(15) == 0) rgh = 8'h00;
         if ($urandom_range(15) == 0) bgh = 8'h00;
         send_record(mid, rgh, bgh, lo);
      end
   endtask

   initial begin
      known_ids[0] = MID_A; known_ids[1] = MID_B; known_ids[2] = MID_C;
      cur_rg[0] = 10'd244; cur_rg[1] = 10'd280; cur_rg[2] = 10'd248;
      idle_pct = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send_record(MID_A, 8'd61, 8'd71, 8'h40);   // unity red
      send_record(MID_B, 8'd70, 8'd81, 8'hf0);
      send_record(MID_C, 8'd62, 8'd72, 8'h00);
      send_record(MID_A, 8'h00, 8'h00, 8'h00);   // zero divisors
      send_record(MID_A, 8'hff, 8'hff, 8'hff);
      send_record(MID_B, 8'h00, 8'hff, 8'hc0);
      send_record(MID_C, 8'hff, 8'h00, 8'h30);
      send_record(8'h00, 8'h55, 8'haa, 8'h0f);   // unknown ids
      send_record(8'hff, 8'haa, 8'h55, 8'hf0);
      send_record(8'h01, 8'h12, 8'h34, 8'h56);
      send_record(MID_A, 8'd10, 8'd200, 8'h00);
      send_record(MID_A, 8'd200, 8'd10, 8'h00);
      load_goldens(10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1, 10'd1);
      send_record(MID_A, 8'h40, 8'h40, 8'h00);   // zero golden
      send_record(MID_B, 8'h40, 8'h40, 8'h00);
      send_record(MID_C, 8'h00, 8'h00, 8'h40);   // unity red and green, max blue gain
      send_record(MID_C, 8'hff, 8'hff, 8'hf0);

      load_goldens(10'd244, 10'd285, 10'd280, 10'd327, 10'd248, 10'd288);
      idle_pct = 0;  random_records(500);
      load_goldens(10'($urandom), 10'($urandom), 10'($urandom),
                   10'($urandom), 10'($urandom), 10'($urandom));
      idle_pct = 72; random_records(500);
      load_goldens(10'd1023, 10'd1023, 10'd1, 10'd1023, 10'd512, 10'd1);
      idle_pct = 22; random_records(500);
      load_goldens(10'($urandom), 10'($urandom), 10'($urandom),
                   10'($urandom), 10'($urandom), 10'($urandom));
      idle_pct = 0;  random_records(500);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("otp_white_balance_gain_core: match");
      else
         $display("otp_white_balance_gain_core: mismatch");
      $finish;
   end
endmodule
